[rtl/core/assert_macros.svh]
// assertion helpers used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, muted while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ffsa_pkg.sv]
package ffsa_pkg;

   localparam int ADDR_W   = 32;
   localparam int ITEMS_W  = 20;
   localparam int STRIDE_W = 13;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = ADDR_W + ITEMS_W;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1;

   // one free span as stored in the table
   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [ITEMS_W-1:0] items;
   } span_type;

endpackage

[rtl/core/ffsa_ram.sv]
module ffsa_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/first_fit_span_allocator.sv]
// First-fit span allocator. Free spans (base block address, item count) sit in an
// address-sorted table in one RAM with a registered read; a small sequencer walks it
// one entry at a time and a single 20x13 multiplier scales item counts by the stride.
// A request scales its count by the stride, then reads and checks each span in turn,
// also evaluating it on return; an entry moved when a span is removed or inserted is
// read and written back. A zero count skips the scan. The request side stalls until the
// current request finishes. The stride register is written through the csr channel,
// which is always ready, and should be written only while the block is idle.
`include "assert_macros.svh"

module first_fit_span_allocator #(
   parameter int MAX_SPANS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [ffsa_pkg::ADDR_W-1:0]   req_address,
   input  logic [ffsa_pkg::ITEMS_W-1:0]  req_num_items,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffsa_pkg::ADDR_W-1:0]   rsp_base_address,
   output logic [ffsa_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ffsa_pkg::STRIDE_W-1:0] csr_data
);

   localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int CW = $clog2(MAX_SPANS + 1);
   localparam logic [CW-1:0] MAX_N = CW'(MAX_SPANS);
   localparam logic [CW-1:0] ONE   = CW'(1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_PRE   = 11'b00000000010,
      S_RD    = 11'b00000000100,
      S_CHK   = 11'b00000001000,
      S_EVAL  = 11'b00000010000,
      S_NRD   = 11'b00000100000,
      S_NCHK  = 11'b00001000000,
      S_MV_RD = 11'b00010000000,
      S_MV_WR = 11'b00100000000,
      S_PUT   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [ffsa_pkg::STRIDE_W-1:0]  stride_ff;
   logic [CW-1:0]                  n_ff, n_in;
   logic [CW-1:0]                  i_ff, i_in;
   logic [CW-1:0]                  j_ff, j_in;
   logic                           mv_up_ff, mv_up_in;
   logic                           act_ff, act_in;
   logic [ffsa_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [ffsa_pkg::ITEMS_W-1:0]   cnt_ff, cnt_in;
   logic [ffsa_pkg::ADDR_W-1:0]    sc_ff, sc_in;
   logic [ffsa_pkg::ADDR_W-1:0]    fend_ff, fend_in;
   logic [ffsa_pkg::ADDR_W-1:0]    prod_ff, prod_in;
   ffsa_pkg::span_type             cur_ff, cur_in;
   logic [ffsa_pkg::ITEMS_W-1:0]   grown_ff, grown_in;
   logic [ffsa_pkg::ADDR_W-1:0]    res_base_ff, res_base_in;
   logic [ffsa_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ffsa_pkg::ADDR_W-1:0]    rsp_base_ff, rsp_base_in;
   logic [ffsa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // table ram port
   logic                           wr_en;
   logic [IW-1:0]                  wr_addr;
   ffsa_pkg::span_type             wr_span;
   logic [IW-1:0]                  rd_addr;
   logic [ffsa_pkg::ENTRY_W-1:0]   rd_raw;
   ffsa_pkg::span_type             rd_span;

   // shared multiplier
   logic [ffsa_pkg::ITEMS_W-1:0]   mul_a;
   logic [ffsa_pkg::ITEMS_W+ffsa_pkg::STRIDE_W-1:0] mul_full;

   logic [ffsa_pkg::ADDR_W-1:0]    span_end;
   logic [ffsa_pkg::ITEMS_W:0]     ext_sum;
   logic [ffsa_pkg::ITEMS_W:0]     merge_sum;
   logic [CW-1:0]                  i_next;
   logic [CW-1:0]                  j_prev;
   logic [CW-1:0]                  j_next;
   logic                           req_xfer;
   logic                           rsp_xfer;

   ffsa_ram #(
      .WIDTH (ffsa_pkg::ENTRY_W),
      .DEPTH (MAX_SPANS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_span),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_span   = ffsa_pkg::span_type'(rd_raw);
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_base_address = rsp_base_ff;
   assign rsp_status       = rsp_status_ff;

   // scaling unit: request count during setup, entry count during a return scan
   assign mul_a    = (state_ff == S_PRE) ? cnt_ff : rd_span.items;
   assign mul_full = mul_a * stride_ff;

   // span end and count checks
   assign span_end  = cur_ff.base + prod_ff;
   assign ext_sum   = {1'b0, cur_ff.items} + {1'b0, cnt_ff};
   assign merge_sum = {1'b0, grown_ff} + {1'b0, rd_span.items};
   assign i_next    = i_ff + ONE;
   assign j_prev    = j_ff - ONE;
   assign j_next    = j_ff + ONE;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      mv_up_in      = mv_up_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      sc_in         = sc_ff;
      fend_in       = fend_ff;
      prod_in       = prod_ff;
      cur_in        = cur_ff;
      grown_in      = grown_ff;
      res_base_in   = res_base_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      rsp_base_in   = rsp_base_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff[IW-1:0];
      wr_span       = cur_ff;
      rd_addr       = i_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in      = req_action;
               addr_in     = req_address;
               cnt_in      = req_num_items;
               i_in        = '0;
               res_base_in = '0;
               if (req_num_items == '0) begin
                  res_status_in = (req_action == ffsa_pkg::ACT_ALLOC) ?
                                  ffsa_pkg::STATUS_NO_FIT : ffsa_pkg::STATUS_OK;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PRE;
               end
            end
         end
         S_PRE: begin
            sc_in    = mul_full[ffsa_pkg::ADDR_W-1:0];
            state_in = S_RD;
         end
         S_RD: begin
            fend_in = addr_ff + sc_ff;
            if (i_ff == n_ff) begin
               if (act_ff == ffsa_pkg::ACT_ALLOC) begin
                  res_status_in = ffsa_pkg::STATUS_NO_FIT;
                  state_in      = S_DONE;
               end else if (n_ff == MAX_N) begin
                  res_status_in = ffsa_pkg::STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  j_in     = n_ff;
                  mv_up_in = 1'b1;
                  state_in = S_MV_RD;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (act_ff == ffsa_pkg::ACT_ALLOC) begin
               if (rd_span.items == cnt_ff) begin
                  res_base_in   = rd_span.base;
                  res_status_in = ffsa_pkg::STATUS_OK;
                  j_in          = i_ff;
                  mv_up_in      = 1'b0;
                  state_in      = S_MV_RD;
               end else if (rd_span.items > cnt_ff) begin
                  wr_en         = 1'b1;
                  wr_span.base  = rd_span.base + sc_ff;
                  wr_span.items = rd_span.items - cnt_ff;
                  res_base_in   = rd_span.base;
                  res_status_in = ffsa_pkg::STATUS_OK;
                  state_in      = S_DONE;
               end else begin
                  i_in     = i_next;
                  state_in = S_RD;
               end
            end else begin
               cur_in   = rd_span;
               prod_in  = mul_full[ffsa_pkg::ADDR_W-1:0];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (span_end == addr_ff && !ext_sum[ffsa_pkg::ITEMS_W]) begin
               // forward extension, maybe merge with the next span
               grown_in = ext_sum[ffsa_pkg::ITEMS_W-1:0];
               res_status_in = ffsa_pkg::STATUS_OK;
               if (i_next < n_ff) begin
                  state_in = S_NRD;
               end else begin
                  wr_en         = 1'b1;
                  wr_span.base  = cur_ff.base;
                  wr_span.items = ext_sum[ffsa_pkg::ITEMS_W-1:0];
                  state_in      = S_DONE;
               end
            end else if (fend_ff == cur_ff.base && !ext_sum[ffsa_pkg::ITEMS_W]) begin
               // backward extension
               wr_en         = 1'b1;
               wr_span.base  = cur_ff.base - sc_ff;
               wr_span.items = ext_sum[ffsa_pkg::ITEMS_W-1:0];
               res_status_in = ffsa_pkg::STATUS_OK;
               state_in      = S_DONE;
            end else if (addr_ff < cur_ff.base) begin
               if (n_ff == MAX_N) begin
                  res_status_in = ffsa_pkg::STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  j_in     = n_ff;
                  mv_up_in = 1'b1;
                  state_in = S_MV_RD;
               end
            end else begin
               i_in     = i_next;
               state_in = S_RD;
            end
         end
         S_NRD: begin
            rd_addr  = i_next[IW-1:0];
            state_in = S_NCHK;
         end
         S_NCHK: begin
            wr_en        = 1'b1;
            wr_span.base = cur_ff.base;
            if (rd_span.base == fend_ff && !merge_sum[ffsa_pkg::ITEMS_W]) begin
               wr_span.items = merge_sum[ffsa_pkg::ITEMS_W-1:0];
               j_in          = i_next;
               mv_up_in      = 1'b0;
               state_in      = S_MV_RD;
            end else begin
               wr_span.items = grown_ff;
               state_in      = S_DONE;
            end
         end
         S_MV_RD: begin
            if (mv_up_ff) begin
               rd_addr = j_prev[IW-1:0];
               if (j_ff == i_ff) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_MV_WR;
               end
            end else begin
               rd_addr = j_next[IW-1:0];
               if (j_next >= n_ff) begin
                  n_in     = n_ff - ONE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MV_WR;
               end
            end
         end
         S_MV_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[IW-1:0];
            wr_span  = rd_span;
            j_in     = mv_up_ff ? j_prev : j_next;
            state_in = S_MV_RD;
         end
         S_PUT: begin
            wr_en         = 1'b1;
            wr_span.base  = addr_ff;
            wr_span.items = cnt_ff;
            n_in          = n_ff + ONE;
            res_status_in = ffsa_pkg::STATUS_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_base_in   = res_base_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stride_ff    <= ffsa_pkg::STRIDE_RESET;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            stride_ff <= csr_data;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      mv_up_ff      <= mv_up_in;
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      sc_ff         <= sc_in;
      fend_ff       <= fend_in;
      prod_ff       <= prod_in;
      cur_ff        <= cur_in;
      grown_ff      <= grown_in;
      res_base_ff   <= res_base_in;
      res_status_ff <= res_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_status_ff <= rsp_status_in;
   end

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, (reset || n_ff <= MAX_N), "span count past table depth")
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_xfer |=> (state_ff != S_IDLE), "idle after request")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "response not from done")
   `ASSERT_CLK(a_count_step, clock, reset, (state_ff == S_IDLE) |=> (n_ff == $past(n_ff)), "span count moved while idle")
   `ASSERT_CLK(a_status_code, clock, reset, rsp_valid_ff |-> (rsp_status_ff != 2'd3), "bad status code")

endmodule
